>>> hw/rtl/perlin_noise_3d_top_assert.svh
// assertion macros for the 3d noise block
// used by the port checker, no other dependencies
`ifndef PERLIN_NOISE_3D_TOP_ASSERT_SVH
`define PERLIN_NOISE_3D_TOP_ASSERT_SVH
// implication checked on every clock, off during reset
`define PN_ASSERT_IMPL(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pn3 check failed");
// next-cycle implication
`define PN_ASSERT_NEXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pn3 check failed");
`endif

>>> hw/rtl/pn3_pkg.sv
`timescale 1ns / 1ps
// shared constants, a type and a helper function for the 3d noise block
// no dependencies
package pn3_pkg;
	localparam int OUT_W = 18;
	localparam int OUT_FRAC = 16;
	localparam int COORD_W = 24;

	typedef logic [7:0] byte_t;

	function automatic byte_t perm(input byte_t i);
		byte_t r;
		case (i)
		8'd0: r=8'd151; 8'd1: r=8'd160; 8'd2: r=8'd137; 8'd3: r=8'd91;
		8'd4: r=8'd90; 8'd5: r=8'd15; 8'd6: r=8'd131; 8'd7: r=8'd13;
		8'd8: r=8'd201; 8'd9: r=8'd95; 8'd10: r=8'd96; 8'd11: r=8'd53;
		8'd12: r=8'd194; 8'd13: r=8'd233; 8'd14: r=8'd7; 8'd15: r=8'd225;
		8'd16: r=8'd140; 8'd17: r=8'd36; 8'd18: r=8'd103; 8'd19: r=8'd30;
		8'd20: r=8'd69; 8'd21: r=8'd142; 8'd22: r=8'd8; 8'd23: r=8'd99;
		8'd24: r=8'd37; 8'd25: r=8'd240; 8'd26: r=8'd21; 8'd27: r=8'd10;
		8'd28: r=8'd23; 8'd29: r=8'd190; 8'd30: r=8'd6; 8'd31: r=8'd148;
		8'd32: r=8'd247; 8'd33: r=8'd120; 8'd34: r=8'd234; 8'd35: r=8'd75;
		8'd36: r=8'd0; 8'd37: r=8'd26; 8'd38: r=8'd197; 8'd39: r=8'd62;
		8'd40: r=8'd94; 8'd41: r=8'd252; 8'd42: r=8'd219; 8'd43: r=8'd203;
		8'd44: r=8'd117; 8'd45: r=8'd35; 8'd46: r=8'd11; 8'd47: r=8'd32;
		8'd48: r=8'd57; 8'd49: r=8'd177; 8'd50: r=8'd33; 8'd51: r=8'd88;
		8'd52: r=8'd237; 8'd53: r=8'd149; 8'd54: r=8'd56; 8'd55: r=8'd87;
		8'd56: r=8'd174; 8'd57: r=8'd20; 8'd58: r=8'd125; 8'd59: r=8'd136;
		8'd60: r=8'd171; 8'd61: r=8'd168; 8'd62: r=8'd68; 8'd63: r=8'd175;
		8'd64: r=8'd74; 8'd65: r=8'd165; 8'd66: r=8'd71; 8'd67: r=8'd134;
		8'd68: r=8'd139; 8'd69: r=8'd48; 8'd70: r=8'd27; 8'd71: r=8'd166;
		8'd72: r=8'd77; 8'd73: r=8'd146; 8'd74: r=8'd158; 8'd75: r=8'd231;
		8'd76: r=8'd83; 8'd77: r=8'd111; 8'd78: r=8'd229; 8'd79: r=8'd122;
		8'd80: r=8'd60; 8'd81: r=8'd211; 8'd82: r=8'd133; 8'd83: r=8'd230;
		8'd84: r=8'd220; 8'd85: r=8'd105; 8'd86: r=8'd92; 8'd87: r=8'd41;
		8'd88: r=8'd55; 8'd89: r=8'd46; 8'd90: r=8'd245; 8'd91: r=8'd40;
		8'd92: r=8'd244; 8'd93: r=8'd102; 8'd94: r=8'd143; 8'd95: r=8'd54;
		8'd96: r=8'd65; 8'd97: r=8'd25; 8'd98: r=8'd63; 8'd99: r=8'd161;
		8'd100: r=8'd1; 8'd101: r=8'd216; 8'd102: r=8'd80; 8'd103: r=8'd73;
		8'd104: r=8'd209; 8'd105: r=8'd76; 8'd106: r=8'd132; 8'd107: r=8'd187;
		8'd108: r=8'd208; 8'd109: r=8'd89; 8'd110: r=8'd18; 8'd111: r=8'd169;
		8'd112: r=8'd200; 8'd113: r=8'd196; 8'd114: r=8'd135; 8'd115: r=8'd130;
		8'd116: r=8'd116; 8'd117: r=8'd188; 8'd118: r=8'd159; 8'd119: r=8'd86;
		8'd120: r=8'd164; 8'd121: r=8'd100; 8'd122: r=8'd109; 8'd123: r=8'd198;
		8'd124: r=8'd173; 8'd125: r=8'd186; 8'd126: r=8'd3; 8'd127: r=8'd64;
		8'd128: r=8'd52; 8'd129: r=8'd217; 8'd130: r=8'd226; 8'd131: r=8'd250;
		8'd132: r=8'd124; 8'd133: r=8'd123; 8'd134: r=8'd5; 8'd135: r=8'd202;
		8'd136: r=8'd38; 8'd137: r=8'd147; 8'd138: r=8'd118; 8'd139: r=8'd126;
		8'd140: r=8'd255; 8'd141: r=8'd82; 8'd142: r=8'd85; 8'd143: r=8'd212;
		8'd144: r=8'd207; 8'd145: r=8'd206; 8'd146: r=8'd59; 8'd147: r=8'd227;
		8'd148: r=8'd47; 8'd149: r=8'd16; 8'd150: r=8'd58; 8'd151: r=8'd17;
		8'd152: r=8'd182; 8'd153: r=8'd189; 8'd154: r=8'd28; 8'd155: r=8'd42;
		8'd156: r=8'd223; 8'd157: r=8'd183; 8'd158: r=8'd170; 8'd159: r=8'd213;
		8'd160: r=8'd119; 8'd161: r=8'd248; 8'd162: r=8'd152; 8'd163: r=8'd2;
		8'd164: r=8'd44; 8'd165: r=8'd154; 8'd166: r=8'd163; 8'd167: r=8'd70;
		8'd168: r=8'd221; 8'd169: r=8'd153; 8'd170: r=8'd101; 8'd171: r=8'd155;
		8'd172: r=8'd167; 8'd173: r=8'd43; 8'd174: r=8'd172; 8'd175: r=8'd9;
		8'd176: r=8'd129; 8'd177: r=8'd22; 8'd178: r=8'd39; 8'd179: r=8'd253;
		8'd180: r=8'd19; 8'd181: r=8'd98; 8'd182: r=8'd108; 8'd183: r=8'd110;
		8'd184: r=8'd79; 8'd185: r=8'd113; 8'd186: r=8'd224; 8'd187: r=8'd232;
		8'd188: r=8'd178; 8'd189: r=8'd185; 8'd190: r=8'd112; 8'd191: r=8'd104;
		8'd192: r=8'd218; 8'd193: r=8'd246; 8'd194: r=8'd97; 8'd195: r=8'd228;
		8'd196: r=8'd251; 8'd197: r=8'd34; 8'd198: r=8'd242; 8'd199: r=8'd193;
		8'd200: r=8'd238; 8'd201: r=8'd210; 8'd202: r=8'd144; 8'd203: r=8'd12;
		8'd204: r=8'd191; 8'd205: r=8'd179; 8'd206: r=8'd162; 8'd207: r=8'd241;
		8'd208: r=8'd81; 8'd209: r=8'd51; 8'd210: r=8'd145; 8'd211: r=8'd235;
		8'd212: r=8'd249; 8'd213: r=8'd14; 8'd214: r=8'd239; 8'd215: r=8'd107;
		8'd216: r=8'd49; 8'd217: r=8'd192; 8'd218: r=8'd214; 8'd219: r=8'd31;
		8'd220: r=8'd181; 8'd221: r=8'd199; 8'd222: r=8'd106; 8'd223: r=8'd157;
		8'd224: r=8'd184; 8'd225: r=8'd84; 8'd226: r=8'd204; 8'd227: r=8'd176;
		8'd228: r=8'd115; 8'd229: r=8'd121; 8'd230: r=8'd50; 8'd231: r=8'd45;
		8'd232: r=8'd127; 8'd233: r=8'd4; 8'd234: r=8'd150; 8'd235: r=8'd254;
		8'd236: r=8'd138; 8'd237: r=8'd236; 8'd238: r=8'd205; 8'd239: r=8'd93;
		8'd240: r=8'd222; 8'd241: r=8'd114; 8'd242: r=8'd67; 8'd243: r=8'd29;
		8'd244: r=8'd24; 8'd245: r=8'd72; 8'd246: r=8'd243; 8'd247: r=8'd141;
		8'd248: r=8'd128; 8'd249: r=8'd195; 8'd250: r=8'd78; 8'd251: r=8'd66;
		8'd252: r=8'd215; 8'd253: r=8'd61; 8'd254: r=8'd156; 8'd255: r=8'd180;
		default: r = 8'd0;
		endcase
		return r;
	endfunction
endpackage

>>> hw/rtl/perlin_noise_3d_top.sv
`timescale 1ns / 1ps
// top level of the 3d gradient noise pipeline
// depends on pn3_pkg and pn3_mulq
//
// usage:
//   in channel: coord_x/y/z (unsigned 8.FRAC_BITS) with in_valid/in_ready
//   out channel: noise_value (signed Q2.16) with out_valid/out_ready
//   one word in, one word out, in order; no state is kept between words
// throughput: one word per cycle, sustained while out_ready is high
// the pipe has twelve stages, in order:
//   capture, five fade steps (6t - 15, then four dependent multiplies)
//   and three lerp levels of a multiply stage and an add stage each
// every stage carries a valid bit; the whole pipe advances on one enable,
//   so in_ready is high whenever the last stage is empty or being taken
// receiver stall: the pipe holds, nothing is dropped or repeated; while
//   the last stage is empty the pipe keeps moving even with out_ready low
// reset: valid bits clear, payload registers are not reset
module perlin_noise_3d_top #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [23:0] coord_x,
	input  logic [23:0] coord_y,
	input  logic [23:0] coord_z,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [17:0] noise_value
);
	localparam int NST = 12;
	// working width: offsets in (-one, one), fade steps and gradient sums
	localparam int W  = FRAC_BITS + 7;
	// scaled result before saturation, room for a left shift to 16 fraction bits
	localparam int MW = FRAC_BITS + 12;
	localparam int OUT_FRAC_L = pn3_pkg::OUT_FRAC;
	localparam int SH = (FRAC_BITS > OUT_FRAC_L) ? FRAC_BITS - OUT_FRAC_L
		: OUT_FRAC_L - FRAC_BITS;

	typedef logic signed [W-1:0] fx_t;
	typedef logic [FRAC_BITS-1:0] fr_t;

	logic [NST-1:0] vld_q;
	logic en;

	assign en        = !vld_q[NST-1] || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-2:0], in_valid};
		end
	end

	// stage 1: capture, hash level one
	// lattice cell is the byte above the fraction, upper bits read as zero
	fr_t fx_s1, fy_s1, fz_s1;
	logic [7:0] iz_s1, a_s1, b_s1;
	logic [7:0] ix, iy, iz;
	assign ix = 8'({8'd0, coord_x} >> FRAC_BITS);
	assign iy = 8'({8'd0, coord_y} >> FRAC_BITS);
	assign iz = 8'({8'd0, coord_z} >> FRAC_BITS);
	always_ff @(posedge clk) begin
		if (en) begin
			fx_s1 <= coord_x[FRAC_BITS-1:0];
			fy_s1 <= coord_y[FRAC_BITS-1:0];
			fz_s1 <= coord_z[FRAC_BITS-1:0];
			iz_s1 <= iz;
			a_s1  <= pn3_pkg::perm(ix) + iy;
			b_s1  <= pn3_pkg::perm(ix + 8'd1) + iy;
		end
	end

	// fade chain: r0 = 6t - 15 at stage 2, then r*t + 10, r*t, r*t, r*t
	localparam fx_t ONE = fx_t'(1) <<< FRAC_BITS;
	fr_t fin_s1 [3];
	fx_t fade_s6 [3];
	assign fin_s1[0] = fx_s1;
	assign fin_s1[1] = fy_s1;
	assign fin_s1[2] = fz_s1;
	genvar gi;
	generate
		for (gi = 0; gi < 3; gi++) begin : g_fade
			fr_t t_s2, t_s3, t_s4, t_s5;
			fx_t r0_s2, m1_s3, m1a, m2_s4, m3_s5, m4_s6;
			always_ff @(posedge clk) begin
				if (en) begin
					r0_s2 <= fx_t'(6) * fx_t'({1'b0, fin_s1[gi]}) - fx_t'(15) * ONE;
					t_s2 <= fin_s1[gi];
					t_s3 <= t_s2;
					t_s4 <= t_s3;
					t_s5 <= t_s4;
				end
			end
			pn3_mulq #(.AW(W), .BW(FRAC_BITS+1), .FB(FRAC_BITS), .RW(W)) u_m1 (
				.clk(clk), .en(en), .a(r0_s2),
				.b(signed'({1'b0, t_s2})), .r_s1(m1_s3));
			assign m1a = m1_s3 + fx_t'(10) * ONE;
			pn3_mulq #(.AW(W), .BW(FRAC_BITS+1), .FB(FRAC_BITS), .RW(W)) u_m2 (
				.clk(clk), .en(en), .a(m1a),
				.b(signed'({1'b0, t_s3})), .r_s1(m2_s4));
			pn3_mulq #(.AW(W), .BW(FRAC_BITS+1), .FB(FRAC_BITS), .RW(W)) u_m3 (
				.clk(clk), .en(en), .a(m2_s4),
				.b(signed'({1'b0, t_s4})), .r_s1(m3_s5));
			pn3_mulq #(.AW(W), .BW(FRAC_BITS+1), .FB(FRAC_BITS), .RW(W)) u_m4 (
				.clk(clk), .en(en), .a(m3_s5),
				.b(signed'({1'b0, t_s5})), .r_s1(m4_s6));
			// fade ready at stage 6: clamp to [0, one]
			assign fade_s6[gi] = (m4_s6 < 0) ? fx_t'(0)
				: ((m4_s6 > ONE) ? ONE : m4_s6);
		end
	endgenerate

	// hash path: stage 2 second level, stage 3 corners
	logic [7:0] aa_s2, ab_s2, ba_s2, bb_s2;
	logic [7:0] h_s3 [8];
	always_ff @(posedge clk) begin
		if (en) begin
			aa_s2 <= pn3_pkg::perm(a_s1) + iz_s1;
			ab_s2 <= pn3_pkg::perm(a_s1 + 8'd1) + iz_s1;
			ba_s2 <= pn3_pkg::perm(b_s1) + iz_s1;
			bb_s2 <= pn3_pkg::perm(b_s1 + 8'd1) + iz_s1;
			// corner order: l0 pair, l1 pair, l2 pair, l3 pair
			h_s3[0] <= pn3_pkg::perm(aa_s2);
			h_s3[1] <= pn3_pkg::perm(ba_s2);
			h_s3[2] <= pn3_pkg::perm(ab_s2);
			h_s3[3] <= pn3_pkg::perm(bb_s2);
			h_s3[4] <= pn3_pkg::perm(aa_s2 + 8'd1);
			h_s3[5] <= pn3_pkg::perm(ba_s2 + 8'd1);
			h_s3[6] <= pn3_pkg::perm(ab_s2 + 8'd1);
			h_s3[7] <= pn3_pkg::perm(bb_s2 + 8'd1);
		end
	end

	// fraction delay to stage 3, then gradients at stage 4
	fr_t fx_s2, fy_s2, fz_s2, fx_s3, fy_s3, fz_s3;
	fx_t g_s4 [8];
	always_ff @(posedge clk) begin
		if (en) begin
			fx_s2 <= fx_s1; fy_s2 <= fy_s1; fz_s2 <= fz_s1;
			fx_s3 <= fx_s2; fy_s3 <= fy_s2; fz_s3 <= fz_s2;
		end
	end
	always_ff @(posedge clk) begin
		fx_t px, py, pz, gu, gv;
		logic [3:0] h;
		if (en) begin
			for (int c = 0; c < 8; c++) begin
				px = fx_t'({1'b0, fx_s3}) - ((c & 1) != 0 ? ONE : fx_t'(0));
				py = fx_t'({1'b0, fy_s3}) - ((c & 2) != 0 ? ONE : fx_t'(0));
				pz = fx_t'({1'b0, fz_s3}) - ((c & 4) != 0 ? ONE : fx_t'(0));
				h  = h_s3[c][3:0];
				gu = (h < 4'd8) ? px : py;
				gv = (h < 4'd4) ? py : ((h == 4'd12 || h == 4'd14) ? px : pz);
				g_s4[c] <= (h[0] ? -gu : gu) + (h[1] ? -gv : gv);
			end
		end
	end

	// delay gradients to stage 6 where fades are ready
	fx_t g_s5 [8], g_s6 [8];
	always_ff @(posedge clk) begin
		if (en) begin
			g_s5 <= g_s4;
			g_s6 <= g_s5;
		end
	end
	// stage 6 -> 8: first lerp level by u (multiply stage 7, add stage 8)
	fx_t d1 [4], p1_s7 [4], a1_s7 [4], l1_s8 [4];
	fx_t v_q [2], w_q [4];
	generate
		for (gi = 0; gi < 4; gi++) begin : g_l1
			assign d1[gi] = g_s6[2*gi+1] - g_s6[2*gi];
			pn3_mulq #(.AW(W), .BW(W), .FB(FRAC_BITS), .RW(W)) u_m (
				.clk(clk), .en(en), .a(d1[gi]), .b(fade_s6[0]), .r_s1(p1_s7[gi]));
		end
	endgenerate
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				a1_s7[i] <= g_s6[2*i];
				l1_s8[i] <= a1_s7[i] + p1_s7[i];
			end
			v_q[0] <= fade_s6[1]; v_q[1] <= v_q[0];
			w_q[0] <= fade_s6[2];
			for (int i = 1; i < 4; i++) w_q[i] <= w_q[i-1];
		end
	end
	// stage 8 -> 10: second level by v
	fx_t d2 [2], p2_s9 [2], a2_s9 [2], l2_s10 [2];
	generate
		for (gi = 0; gi < 2; gi++) begin : g_l2
			assign d2[gi] = l1_s8[2*gi+1] - l1_s8[2*gi];
			pn3_mulq #(.AW(W), .BW(W), .FB(FRAC_BITS), .RW(W)) u_m (
				.clk(clk), .en(en), .a(d2[gi]), .b(v_q[1]), .r_s1(p2_s9[gi]));
		end
	endgenerate
	// stage 10 -> 12: last lerp by w (multiply stage 11), then add, scale
	// and saturate into the output register
	fx_t d3, p3_s11, a3_s11, r3;
	logic signed [MW-1:0] sc;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 2; i++) begin
				a2_s9[i]  <= l1_s8[2*i];
				l2_s10[i] <= a2_s9[i] + p2_s9[i];
			end
			a3_s11 <= l2_s10[0];
		end
	end
	assign d3 = l2_s10[1] - l2_s10[0];
	pn3_mulq #(.AW(W), .BW(W), .FB(FRAC_BITS), .RW(W)) u_m3 (
		.clk(clk), .en(en), .a(d3), .b(w_q[3]), .r_s1(p3_s11));
	assign r3 = a3_s11 + p3_s11;
	generate
		if (FRAC_BITS > OUT_FRAC_L) begin : g_dn
			// round half up while dropping the extra fraction bits
			assign sc = MW'((MW'(r3) + (MW'(1) <<< (SH - 1))) >>> SH);
		end else begin : g_up
			assign sc = MW'(r3) <<< SH;
		end
	endgenerate
	always_ff @(posedge clk) begin
		if (en) begin
			if (sc > MW'(131071)) noise_value <= 18'sd131071;
			else if (sc < -MW'(131072)) noise_value <= {1'b1, 17'd0};
			else noise_value <= sc[17:0];
		end
	end
endmodule

>>> hw/rtl/pn3_mulq.sv
`timescale 1ns / 1ps
// rounded fixed-point multiply, one register stage
// depends on nothing else
module pn3_mulq #(
	parameter int AW = 20,
	parameter int BW = 20,
	parameter int FB = 16,
	parameter int RW = 20
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [AW-1:0] a,
	input  logic signed [BW-1:0] b,
	output logic signed [RW-1:0] r_s1
);
	logic signed [AW+BW:0] prod;
	logic signed [AW+BW:0] rnd;
	always_comb begin
		prod = (AW+BW+1)'(a) * (AW+BW+1)'(b);
		rnd  = prod + (AW+BW+1)'(signed'({1'b0, 1'b1, {(FB-1){1'b0}}}));
	end
	// arithmetic shift is floor, matching the rounding rule
	always_ff @(posedge clk) begin
		if (en) begin
			r_s1 <= RW'(rnd >>> FB);
		end
	end
endmodule

>>> hw/rtl/perlin_noise_3d_top_chk.sv
`timescale 1ns / 1ps
// port checker for the 3d noise block, bound to the top level
// depends on perlin_noise_3d_top_assert.svh
`include "perlin_noise_3d_top_assert.svh"
module perlin_noise_3d_top_chk (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic signed [17:0] noise_value
);
	`PN_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(noise_value))
	`PN_ASSERT_IMPL(a_ready_free, clk, arst_n, !out_valid, in_ready)
	`PN_ASSERT_IMPL(a_ready_stall, clk, arst_n, out_valid && !out_ready, !in_ready)
endmodule
bind perlin_noise_3d_top perlin_noise_3d_top_chk u_chk (.*);

>>> dv/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for perlin_noise_3d_top: random and directed coordinates,
// expected noise computed by an in-bench fixed-point predictor
// depends on pn3_pkg and the perlin_noise_3d_top rtl
module tb;
	localparam int FB = 16;
	localparam longint ONE = 64'sd1 << FB;
	localparam int N_RANDOM = 880;
	localparam int MAX_SHOWN = 10;

	typedef struct packed {
		logic [23:0] x;
		logic [23:0] y;
		logic [23:0] z;
	} point_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [23:0] coord_x, coord_y, coord_z;
	logic out_valid;
	logic out_ready;
	logic signed [17:0] noise_value;

	perlin_noise_3d_top #(.FRAC_BITS(FB)) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.noise_value(noise_value)
	);

	// pending input words and expected noise values
	point_t pending_points[$];
	logic signed [17:0] expected_noise[$];
	int mismatches = 0;
	int sender_idle_pct = 27;
	int receiver_idle_pct = 83;
	bit hold_off = 0;
	// acceptance seen at the rising edge, used by the driver on the falling edge
	bit in_ready_seen = 0;

	// floor division by 2^sh
	function automatic longint fdiv(longint p, int sh);
		return p >>> sh;
	endfunction

	// fixed-point product, rounded half up
	function automatic longint fx_mul(longint a, longint b);
		return fdiv(a * b + (ONE >>> 1), FB);
	endfunction

	function automatic longint fade(longint t);
		longint r;
		r = 6 * t - 15 * ONE;
		r = fx_mul(r, t) + 10 * ONE;
		r = fx_mul(r, t);
		r = fx_mul(r, t);
		r = fx_mul(r, t);
		if (r < 0) r = 0;
		if (r > ONE) r = ONE;
		return r;
	endfunction

	function automatic longint blend(longint a, longint b, longint w);
		return a + fx_mul(b - a, w);
	endfunction

	// gradient dot product selected by the low four hash bits
	function automatic longint grad_dot(logic [7:0] h8, longint x, longint y, longint z);
		logic [3:0] h;
		longint u, v;
		h = h8[3:0];
		u = (h < 8) ? x : y;
		v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
		return (h[0] ? -u : u) + (h[1] ? -v : v);
	endfunction

	function automatic logic signed [17:0] noise_at(point_t p);
		logic [7:0] ix, iy, iz, a, b, aa, ab, ba, bb;
		longint x, y, z, x1, y1, z1, u, v, w, l0, l1, l2, l3, r;
		ix = p.x[23:16]; iy = p.y[23:16]; iz = p.z[23:16];
		x = p.x[15:0]; y = p.y[15:0]; z = p.z[15:0];
		x1 = x - ONE; y1 = y - ONE; z1 = z - ONE;
		u = fade(x); v = fade(y); w = fade(z);
		// byte adds wrap modulo 256, same as the rom index mask
		a = pn3_pkg::perm(ix) + iy;
		b = pn3_pkg::perm(ix + 8'd1) + iy;
		aa = pn3_pkg::perm(a) + iz; ab = pn3_pkg::perm(a + 8'd1) + iz;
		ba = pn3_pkg::perm(b) + iz; bb = pn3_pkg::perm(b + 8'd1) + iz;
		l0 = blend(grad_dot(pn3_pkg::perm(aa), x, y, z),
			grad_dot(pn3_pkg::perm(ba), x1, y, z), u);
		l1 = blend(grad_dot(pn3_pkg::perm(ab), x, y1, z),
			grad_dot(pn3_pkg::perm(bb), x1, y1, z), u);
		l2 = blend(grad_dot(pn3_pkg::perm(aa + 8'd1), x, y, z1),
			grad_dot(pn3_pkg::perm(ba + 8'd1), x1, y, z1), u);
		l3 = blend(grad_dot(pn3_pkg::perm(ab + 8'd1), x, y1, z1),
			grad_dot(pn3_pkg::perm(bb + 8'd1), x1, y1, z1), u);
		r = blend(blend(l0, l1, v), blend(l2, l3, v), w);
		if (r > 131071) r = 131071;
		if (r < -131072) r = -131072;
		return r[17:0];
	endfunction

	function automatic logic [23:0] rand_coord();
		case ($urandom_range(0, 9))
		0: return {8'($urandom_range(0, 255)), 16'h0000};
		1: return {8'($urandom_range(0, 255)), 16'hffff};
		2: return {8'($urandom_range(0, 255)), 16'h8000};
		3: return {8'($urandom_range(0, 255)), 16'($urandom_range(0, 3))};
		default: return 24'($urandom);
		endcase
	endfunction

	// 10 ns clock
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// reset asserted at start, released on a falling edge
	initial begin
		arst_n = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
	end

	// stimulus: directed corners and edges, then random points
	initial begin
		point_t p;
		logic [23:0] edges[6];
		edges = '{24'h000000, 24'hffffff, 24'h00ffff, 24'hff0000, 24'h008000, 24'h7f8001};
		for (int i = 0; i < 6; i++) begin
			p = '{edges[i], edges[i], edges[i]};
			pending_points.push_back(p);
		end
		for (int i = 0; i < 6; i++) begin
			// mixed extremes per axis
			p = '{edges[i], edges[(i + 1) % 6], edges[(i + 3) % 6]};
			pending_points.push_back(p);
		end
		// every gradient code shows up across lattice cells
		for (int i = 0; i < 12; i++) begin
			p = '{{i[7:0], 16'h4000}, {8'(i * 21), 16'hc000}, {8'(255 - i), 16'h2000}};
			pending_points.push_back(p);
		end
		for (int i = 0; i < N_RANDOM; i++) begin
			p = '{rand_coord(), rand_coord(), rand_coord()};
			pending_points.push_back(p);
		end
	end

	// idle profile phases and one long receiver hold-off
	initial begin
		int hold_cycles;
		wait (arst_n);
		wait (pending_points.size() < 640);
		sender_idle_pct = 83;
		receiver_idle_pct = 27;
		wait (pending_points.size() < 500);
		// long stall so the pipe fills and in_ready drops
		hold_off = 1;
		hold_cycles = 0;
		while (hold_cycles < 60) begin
			@(posedge clk);
			hold_cycles++;
		end
		hold_off = 0;
		wait (pending_points.size() < 320);
		sender_idle_pct = 0;
		receiver_idle_pct = 0;
	end

	// driver: valid holds with stable payload until accepted
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			coord_x <= '0;
			coord_y <= '0;
			coord_z <= '0;
			out_ready <= 0;
		end else begin
			out_ready <= !hold_off && ($urandom_range(0, 99) >= receiver_idle_pct);
			if (!in_valid || in_ready_seen) begin
				if (pending_points.size() > 0 &&
						$urandom_range(0, 99) >= sender_idle_pct) begin
					in_valid <= 1;
					coord_x <= pending_points[0].x;
					coord_y <= pending_points[0].y;
					coord_z <= pending_points[0].z;
					void'(pending_points.pop_front());
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	always @(posedge clk) begin
		in_ready_seen <= in_valid && in_ready;
		if (arst_n && in_valid && in_ready)
			expected_noise.push_back(noise_at('{coord_x, coord_y, coord_z}));
	end

	// monitor: compare each accepted word with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_noise.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("unexpected output word noise_value=%0d", noise_value);
			end else begin
				if (noise_value !== expected_noise[0]) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display("noise mismatch: expected %0d got %0d",
							expected_noise[0], noise_value);
				end
				void'(expected_noise.pop_front());
			end
		end
	end

	// end of run: drain, then allow pipeline latency for stray words
	initial begin
		wait (arst_n);
		wait (pending_points.size() == 0);
		@(posedge clk);
		while (in_valid) @(posedge clk);
		wait (expected_noise.size() == 0);
		repeat (30) @(posedge clk);
		if (mismatches == 0 && expected_noise.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// watchdog
	initial begin
		#2ms;
		$display("Test completed with failures");
		$finish;
	end
endmodule
